FILE: rtl/plu_pkg.sv
// Package for the positional list engine: request, result and cell command types.
`default_nettype none
package plu_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CAPACITY_MAX = 64;
  localparam int CELL_IDX_W   = $clog2(CAPACITY_MAX);
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int CNT_W        = 5;
  localparam int CMP_W        = POS_W + 1;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_DUMP     = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_ROT
  } cmd_kind_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [DATA_W-1:0]   value;
    logic        [POS_W-1:0]    position;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic        [CNT_W-1:0]    entry_count;
    logic signed [DATA_W-1:0]   entry_value;
    logic                       entry_valid;
    logic                       last;
  } res_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [CELL_IDX_W-1:0]      idx;
    logic signed [DATA_W-1:0]   value;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/plu_cell.sv
// One list cell: holds one entry and shifts, loads or holds on the broadcast command.
`default_nettype none
module plu_cell #(
  parameter int INDEX = 0
) (
  input  wire                              clk,
  input  plu_pkg::cell_cmd_t               cmd,
  input  wire logic signed [plu_pkg::DATA_W-1:0] left,
  input  wire logic signed [plu_pkg::DATA_W-1:0] right,
  input  wire logic signed [plu_pkg::DATA_W-1:0] head,
  output logic signed [plu_pkg::DATA_W-1:0]      q
);
  import plu_pkg::*;

  localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(INDEX);

  logic signed [DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (cmd.kind)
      CMD_HOLD: q_next = q;
      CMD_INS: begin
        if (MY_IDX > cmd.idx) begin
          q_next = left;
        end else if (MY_IDX == cmd.idx) begin
          q_next = cmd.value;
        end
      end
      CMD_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          q_next = right;
        end
      end
      CMD_ROT: begin
        // rotate towards the head, head wraps to the tail slot
        q_next = (MY_IDX == cmd.idx) ? head : right;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire

FILE: rtl/plu_ctrl.sv
// Sequencer: decodes requests, keeps the count, drives the cell chain and the result register.
`default_nettype none
module plu_ctrl #(
  parameter int CAPACITY = plu_pkg::CAPACITY_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              req_valid,
  output logic                             req_stall,
  input  plu_pkg::req_t                    req,
  output logic                             res_valid,
  input  wire                              res_stall,
  output plu_pkg::res_t                    res,
  input  wire logic signed [plu_pkg::DATA_W-1:0] head,
  output plu_pkg::cell_cmd_t               cmd
);
  import plu_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

  state_t            state, state_next;
  logic [OCC_W-1:0]  occ, occ_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic              res_valid_next;
  res_t              res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      cnt       <= cnt_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_comb begin
    logic             slot_free;
    logic             accept;
    logic [CMP_W-1:0] pos9;
    logic [CMP_W-1:0] occ9;
    logic [OCC_W-1:0] occ_m1;
    logic [CMP_W-1:0] pos_m1;
    status_t          status;
    logic             dump_last;

    slot_free = !res_valid || !res_stall;
    req_stall = (state == S_DUMP) || !slot_free;
    accept    = req_valid && !req_stall;
    pos9      = CMP_W'(req.position);
    occ9      = CMP_W'(occ);
    occ_m1    = occ - OCC_W'(1);
    pos_m1    = pos9 - CMP_W'(1);
    status    = ST_OK;
    dump_last = (cnt == IDX_W'(occ_m1));

    state_next     = state;
    occ_next       = occ;
    cnt_next       = cnt;
    res_valid_next = res_valid && res_stall;
    res_next       = res;
    cmd.kind       = CMD_HOLD;
    cmd.idx        = '0;
    cmd.value      = req.value;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.opcode)
            OP_INS_HEAD, OP_INS_TAIL: begin
              if (occ == OCC_FULL) begin
                status = ST_FULL;
              end else begin
                cmd.kind = CMD_INS;
                cmd.idx  = (req.opcode == OP_INS_HEAD) ? '0 : CELL_IDX_W'(occ);
                occ_next = occ + OCC_W'(1);
              end
            end
            OP_INS_POS: begin
              if (pos9 == '0 || pos9 > occ9 + CMP_W'(1)) begin
                status = ST_BADPOS;
              end else if (occ == OCC_FULL) begin
                status = ST_FULL;
              end else begin
                cmd.kind = CMD_INS;
                cmd.idx  = CELL_IDX_W'(pos_m1);
                occ_next = occ + OCC_W'(1);
              end
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
              if (occ == '0) begin
                status = ST_EMPTY;
              end else begin
                cmd.kind = CMD_DEL;
                cmd.idx  = (req.opcode == OP_DEL_HEAD) ? '0 : CELL_IDX_W'(occ_m1);
                occ_next = occ_m1;
              end
            end
            OP_DEL_POS: begin
              if (pos9 == '0 || pos9 > occ9) begin
                status = ST_BADPOS;
              end else begin
                cmd.kind = CMD_DEL;
                cmd.idx  = CELL_IDX_W'(pos_m1);
                occ_next = occ_m1;
              end
            end
            OP_DUMP: begin
              status = ST_OK;
            end
            default: status = ST_OK;
          endcase

          if (req.opcode == OP_DUMP && occ != '0) begin
            state_next = S_DUMP;
            cnt_next   = '0;
          end else begin
            res_valid_next       = 1'b1;
            res_next.status      = status;
            res_next.entry_count = CNT_W'(occ_next);
            res_next.entry_value = '0;
            res_next.entry_valid = 1'b0;
            res_next.last        = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cmd.kind             = CMD_ROT;
          cmd.idx              = CELL_IDX_W'(occ_m1);
          res_valid_next       = 1'b1;
          res_next.status      = ST_OK;
          res_next.entry_count = CNT_W'(occ);
          res_next.entry_value = head;
          res_next.entry_valid = 1'b1;
          res_next.last        = dump_last;
          cnt_next             = cnt + IDX_W'(1);
          if (dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/positional_list_engine_unit.sv
// Positional list engine: bounded ordered list of signed 32-bit entries held in a cell chain.
//
// Requests arrive on req/req_valid/req_stall, results leave on res/res_valid/res_stall;
// a transfer happens on a rising edge with valid high and stall low.
// Each request is one operation: insert or delete at head, tail or 1-based position, or dump.
// Edits finish in the cycle of acceptance; every cell shifts or holds in one step, so a
// new edit request can be taken every cycle while results keep being taken.
// The single result of an edit appears in the result register in the cycle after acceptance.
// A dump rotates the chain once round: one result per entry, one entry per cycle while
// results are taken, head first, last set on the tail entry; the list is intact afterwards.
// The dump state is registered first, then the first entry; a dump holds off further requests
// until its tail entry is registered; an empty dump holds off nothing and answers next cycle.
// req_stall is high while a dump streams or while an undelivered result is stalled.
// A stalled result holds; the chain does not move until the result is taken.
// Reset (synchronous, active high) empties the list and drops any pending result;
// cell contents are left as they are and are never read before being written.
`default_nettype none
module positional_list_engine_unit #(
  parameter int CAPACITY = plu_pkg::CAPACITY_DEF
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           req_valid,
  output logic          req_stall,
  input  plu_pkg::req_t req,
  output logic          res_valid,
  input  wire           res_stall,
  output plu_pkg::res_t res
);
  import plu_pkg::*;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  cell_cmd_t                cmd;

  plu_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .head      (cell_q[0]),
    .cmd       (cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == CAPACITY - 1) ? i : i + 1;

    plu_cell #(
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .left  (cell_q[L]),
      .right (cell_q[R]),
      .head  (cell_q[0]),
      .q     (cell_q[i])
    );
  end

endmodule
`default_nettype wire

FILE: rtl/plu_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
`default_nettype none
module plu_checker #(
  parameter int CAPACITY = plu_pkg::CAPACITY_DEF
) (
  input wire           clk,
  input wire           rst,
  input wire           req_valid,
  input wire           req_stall,
  input plu_pkg::req_t req,
  input wire           res_valid,
  input wire           res_stall,
  input plu_pkg::res_t res
);
  import plu_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

  // dumped entries always report ok
  a_dump_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.entry_valid |-> res.status == ST_OK)
    else $error("dumped entry with non-ok status");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.entry_valid |-> res.entry_value == '0)
    else $error("entry_value not zero on non-dump result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (CAPACITY > 31) || (res.entry_count <= CNT_MAX))
    else $error("entry_count beyond capacity");

  // a dump streams without gaps once started
  a_dump_stream: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last && !res_stall |=> res_valid && res.entry_valid)
    else $error("gap inside a dump");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

endmodule

bind positional_list_engine_unit plu_checker #(.CAPACITY(CAPACITY)) u_plu_checker (.*);
`default_nettype wire
